@@ hdl/sktr_pkg.sv @@
// shared types and constants for the scancode key state tracker
package sktr_pkg;

    localparam int NUM_KEYS   = 256;
    localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
    localparam int CODE_W     = 8;

    localparam logic [CODE_W-1:0] PREFIX_BYTE = 8'hE0;

    // item kind carried on tuser
    typedef enum logic [1:0] {
        MODE_SCAN  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // key table write request from the filter
    typedef struct packed {
        logic                 en;
        logic [KEY_IDX_W-1:0] idx;
        logic                 brk;
    } key_wr_t;

    // three status bits of one key
    typedef struct packed {
        logic hit;
        logic pressed;
        logic released;
    } key_bits_t;

endpackage

@@ hdl/sktr_filter.sv @@
// repeat filter and extended-prefix tracking for incoming scancode bytes
module sktr_filter
    import sktr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [CODE_W-1:0] code,
    output logic              take,
    output key_wr_t           key_wr
);

    logic [CODE_W-1:0] previous_code_reg;
    logic [CODE_W-1:0] special_now_reg;
    logic [CODE_W-1:0] special_before_reg;
    logic              prefix_pending_reg;

    logic [CODE_W-1:0] special_now_next;
    logic              prefix_pending_next;
    logic              is_prefix;

    // filter decision
    always_comb
    begin
        is_prefix = (code == PREFIX_BYTE);
        if (previous_code_reg == PREFIX_BYTE)
        begin
            special_now_next = code;
        end
        else if (!is_prefix)
        begin
            special_now_next = '0;
        end
        else
        begin
            special_now_next = special_now_reg;
        end
        take = (code != previous_code_reg) &&
               ((special_now_next != special_before_reg) || (special_before_reg == '0));
    end

    // prefix handling and key write request
    always_comb
    begin
        prefix_pending_next = prefix_pending_reg;
        key_wr.en  = 1'b0;
        key_wr.idx = {prefix_pending_reg, code[CODE_W-2:0]};
        key_wr.brk = code[CODE_W-1];
        if (en && take)
        begin
            if (is_prefix)
            begin
                prefix_pending_next = 1'b1;
            end
            else
            begin
                prefix_pending_next = 1'b0;
                key_wr.en           = 1'b1;
            end
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_code_reg  <= '0;
            special_now_reg    <= '0;
            special_before_reg <= '0;
            prefix_pending_reg <= 1'b0;
        end
        else
        begin
            prefix_pending_reg <= prefix_pending_next;
            if (en)
            begin
                previous_code_reg  <= code;
                special_now_reg    <= special_now_next;
                special_before_reg <= special_now_next;
            end
        end
    end

endmodule

@@ hdl/sktr_key_table.sv @@
// hit, pressed and released bits for every key, with frame clear
module sktr_key_table
    import sktr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  key_wr_t              key_wr,
    input  logic                 clear,
    input  logic [KEY_IDX_W-1:0] rd_idx,
    output key_bits_t            rd_bits
);

    logic [NUM_KEYS-1:0] hit_reg;
    logic [NUM_KEYS-1:0] pressed_reg;
    logic [NUM_KEYS-1:0] released_reg;
    logic [NUM_KEYS-1:0] hit_next;
    logic [NUM_KEYS-1:0] pressed_next;
    logic [NUM_KEYS-1:0] released_next;

    // single key lookup
    assign rd_bits.hit      = hit_reg[rd_idx];
    assign rd_bits.pressed  = pressed_reg[rd_idx];
    assign rd_bits.released = released_reg[rd_idx];

    // make, break and clear updates
    always_comb
    begin
        hit_next      = clear ? '0 : hit_reg;
        pressed_next  = pressed_reg;
        released_next = clear ? '0 : released_reg;
        if (key_wr.en)
        begin
            if (key_wr.brk)
            begin
                pressed_next[key_wr.idx]  = 1'b0;
                released_next[key_wr.idx] = 1'b1;
            end
            else
            begin
                hit_next[key_wr.idx]     = 1'b1;
                pressed_next[key_wr.idx] = 1'b1;
            end
        end
    end

    // key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= '0;
            pressed_reg  <= '0;
            released_reg <= '0;
        end
        else
        begin
            hit_reg      <= hit_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
        end
    end

endmodule

@@ hdl/scancode_key_state_tracker_top.sv @@
// top level: input register, filter and key table, result register
//
//  channel  | direction | tdata (low bit up)                       | tuser
//  ---------+-----------+------------------------------------------+-----------
//  s_axis   | in        | scan_code[7:0], key_index[15:8]          | mode[1:0]
//  m_axis   | out       | code_accepted, key_hit, key_pressed,     | -
//           |           | key_released, zero pad [7:4]             |
//
// one item per clock sustained while m_tready stays high; an input transfer is held in
// the input register, then in the result register, before its result is valid on m_axis
// reset clears the filter state, the prefix flag, all key bits and both
// valid flags; no clearing pass is needed
// a stalled result holds the result register, the input register fills
// behind it, and s_tready drops only when both are occupied
module scancode_key_state_tracker_top
    import sktr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // scan_code[7:0], key_index[15:8]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // code_accepted, key_hit, key_pressed, key_released, pad
);

    logic                 in_valid_reg;
    logic [1:0]           in_mode_reg;
    logic [CODE_W-1:0]    in_code_reg;
    logic [KEY_IDX_W-1:0] in_key_reg;

    logic                 out_valid_reg;
    logic [3:0]           out_data_reg;
    logic [3:0]           out_data_next;

    logic                 advance;
    logic                 scan_en;
    logic                 clear_en;
    logic                 take;
    key_wr_t              key_wr;
    key_bits_t            rd_bits;

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    assign scan_en  = advance && (in_mode_reg == MODE_SCAN);
    assign clear_en = advance && (in_mode_reg == MODE_CLEAR);

    sktr_filter u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (scan_en),
        .code   (in_code_reg),
        .take   (take),
        .key_wr (key_wr)
    );

    sktr_key_table u_key_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_wr  (key_wr),
        .clear   (clear_en),
        .rd_idx  (in_key_reg),
        .rd_bits (rd_bits)
    );

    // result fields by mode
    always_comb
    begin
        case (in_mode_reg)
            MODE_SCAN:  out_data_next = {3'b000, take};
            MODE_QUERY: out_data_next = {rd_bits.released, rd_bits.pressed, rd_bits.hit, 1'b0};
            default:    out_data_next = '0;
        endcase
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_code_reg <= s_tdata[7:0];
            in_key_reg  <= s_tdata[15:8];
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // an accepted byte result never carries key bits
    a_accept_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[0] |-> out_data_reg[3:1] == 3'b000)
        else $error("accepted byte result carries key bits");

    // a waiting item holds while the result side is stalled
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_code_reg)
            && $stable(in_mode_reg) && $stable(in_key_reg))
        else $error("input register changed while stalled");

    // key writes only come from a scancode item moving on
    a_wr_scan: assert property (@(posedge clk) disable iff (!rst_n)
        key_wr.en |-> scan_en && take)
        else $error("key write without accepted scancode");

    // an empty input register always takes a transfer
    a_no_lost_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input blocked while input register empty");

endmodule
